@@ rtl/core/rcpdm_pkg.sv @@
`timescale 1ns / 1ps

package rcpdm_pkg;

  // Pulse acceptance window (us) and neutral stick position
  localparam int PULSE_MIN_OK = 600;
  localparam int PULSE_MAX_OK = 2400;
  localparam int NEUTRAL_POS  = 256;
  localparam int DUTY_TOP     = 255;

  // Mixer register widths
  localparam int REG9_W    = 9;
  localparam int REG_IDX_W = 3;

  // Register reset values
  localparam int CAL_LOW_RST   = 1100;
  localparam int CAL_HIGH_RST  = 1900;
  localparam int DB_UPPER_RST  = 275;
  localparam int DB_LOWER_RST  = 235;
  localparam int CTR_UP_RST    = 256;
  localparam int CTR_DOWN_RST  = 255;

  // Configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_STEER_CAL_LOW,
    REG_STEER_CAL_HIGH,
    REG_THROTTLE_CAL_LOW,
    REG_THROTTLE_CAL_HIGH,
    REG_DEADBAND_UPPER,
    REG_DEADBAND_LOWER,
    REG_CENTER_UP,
    REG_CENTER_DOWN
  } reg_idx_t;

  // Motor direction codes
  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MULT,
    ST_DIV,
    ST_SAT,
    ST_MIX
  } state_t;

  // Mixed motor drive
  typedef struct packed {
    logic [7:0] left_duty;
    dir_t       left_dir;
    logic [7:0] right_duty;
    dir_t       right_dir;
    logic       neutral_lamp;
  } mix_t;

endpackage

@@ rtl/core/rcpdm_mix.sv @@
`timescale 1ns / 1ps

module rcpdm_mix import rcpdm_pkg::*; #(
  parameter int POS_W = 9
) (
  input  logic [POS_W-1:0]  steer_pos,
  input  logic [POS_W-1:0]  throttle_pos,
  input  logic [REG9_W-1:0] deadband_upper,
  input  logic [REG9_W-1:0] deadband_lower,
  input  logic [REG9_W-1:0] center_up,
  input  logic [REG9_W-1:0] center_down,
  output mix_t              mix
);

  localparam int MW = ((POS_W > REG9_W) ? POS_W : REG9_W) + 3;
  localparam logic signed [MW-1:0] ONE_S    = MW'(1);
  localparam logic signed [MW-1:0] TOP_M1_S = MW'(DUTY_TOP - 1);

  logic signed [MW-1:0] x, y, up, lo, cu, cd;
  logic signed [MW-1:0] ycu, cdy, xcu, cdx;
  logic signed [MW-1:0] a, b, turn, half;

  function automatic logic [7:0] sat_duty(input logic signed [MW-1:0] d);
    logic [7:0] r;
    if (d < ONE_S) begin
      r = 8'd0;
    end else if (d > TOP_M1_S) begin
      r = 8'(DUTY_TOP);
    end else begin
      r = d[7:0];
    end
    return r;
  endfunction

  // Zero-extend everything into one signed working width
  assign x  = $signed({{(MW-POS_W){1'b0}}, steer_pos});
  assign y  = $signed({{(MW-POS_W){1'b0}}, throttle_pos});
  assign up = $signed({{(MW-REG9_W){1'b0}}, deadband_upper});
  assign lo = $signed({{(MW-REG9_W){1'b0}}, deadband_lower});
  assign cu = $signed({{(MW-REG9_W){1'b0}}, center_up});
  assign cd = $signed({{(MW-REG9_W){1'b0}}, center_down});

  assign ycu = y - cu;
  assign cdy = cd - y;
  assign xcu = x - cu;
  assign cdx = cd - x;

  // Spin-in-place duty: half of the stick offset, truncated toward zero
  assign turn = (x > up) ? xcu : cdx;
  assign half = (turn + $signed({{(MW-1){1'b0}}, turn[MW-1]})) >>> 1;

  // Tank mixing with deadbands
  always_comb begin
    a                = '0;
    b                = '0;
    mix.left_dir     = DIR_STOP;
    mix.right_dir    = DIR_STOP;
    mix.neutral_lamp = 1'b0;
    if (y > up) begin
      mix.left_dir  = DIR_FWD;
      mix.right_dir = DIR_FWD;
      if (x > up) begin
        a = ycu;
        b = ycu - xcu;
      end else if (x < lo) begin
        a = ycu - cdx;
        b = ycu;
      end else begin
        a = ycu;
        b = ycu;
      end
    end else if (y < lo) begin
      mix.left_dir  = DIR_REV;
      mix.right_dir = DIR_REV;
      if (x > up) begin
        a = cdy;
        b = cdy - xcu;
      end else if (x < lo) begin
        a = cdy - cdx;
        b = cdy;
      end else begin
        a = cdy;
        b = cdy;
      end
    end else begin
      if (x > up) begin
        a             = half;
        b             = half;
        mix.left_dir  = DIR_REV;
        mix.right_dir = DIR_FWD;
      end else if (x < lo) begin
        a             = half;
        b             = half;
        mix.left_dir  = DIR_FWD;
        mix.right_dir = DIR_REV;
      end else begin
        mix.neutral_lamp = 1'b1;
      end
    end
    mix.left_duty  = sat_duty(a);
    mix.right_duty = sat_duty(b);
  end

endmodule

@@ rtl/core/rc_pulse_differential_drive_mixer.sv @@
`timescale 1ns / 1ps

// Tank-steering mixer for two RC servo pulse channels. Each input beat is one
// measured pulse width for steering (channel_select 0) or throttle (1). A pulse
// inside 600..2400 us is scaled from its channel's calibration range onto
// 0..POSITION_MAX by one shared restoring divider that retires one quotient
// bit per cycle, then clamped and stored; otherwise the stored position is
// kept and pulse_valid is 0. Every beat produces one result beat with both
// motor duties and directions mixed from the stored positions. A valid pulse
// passes through the prepare, multiply, divide, saturate and mix steps; an
// invalid pulse or equal calibration bounds go from prepare straight to mix.
// in_ready is low while a beat is being worked on; the result sits in an
// output register, so a new beat is taken while it waits.
// Both positions reset to 256. Configuration writes are taken at any time
// but must only be issued while the block is idle.
module rc_pulse_differential_drive_mixer import rcpdm_pkg::*; #(
  parameter int POSITION_MAX = 511,
  parameter int PULSE_BITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [PULSE_BITS-1:0] cfg_data,
  // pulse input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_channel_select,
  input  logic [PULSE_BITS-1:0] in_pulse_width_us,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_pulse_valid,
  output logic [7:0]            out_left_duty,
  output logic [1:0]            out_left_dir,
  output logic [7:0]            out_right_duty,
  output logic [1:0]            out_right_dir,
  output logic                  out_neutral_lamp
);

  localparam int PW    = PULSE_BITS;
  localparam int PMW   = $clog2(POSITION_MAX + 1);
  localparam int POS_W = (PMW > REG9_W) ? PMW : REG9_W;
  localparam int NW    = PW + PMW;
  localparam int CW    = $clog2(NW + 1);
  localparam logic [PMW-1:0]   PM_C    = PMW'(POSITION_MAX);
  localparam logic [POS_W-1:0] PM_POS  = POS_W'(POSITION_MAX);
  localparam logic [NW-1:0]    PM_Q    = NW'(POSITION_MAX);
  localparam logic [CW-1:0]    LAST_IT = CW'(NW - 1);

  // Configuration registers
  logic [PW-1:0]     steer_lo_r, steer_hi_r, thr_lo_r, thr_hi_r;
  logic [REG9_W-1:0] db_upper_r, db_lower_r, ctr_up_r, ctr_down_r;

  // Sequencer and datapath registers
  state_t          state_r, state_nxt;
  logic            sel_r;
  logic [PW-1:0]   pulse_r;
  logic            ok_r;
  logic [PW-1:0]   diff_mag_r, diff_mag_nxt;
  logic [PW-1:0]   den_mag_r, den_mag_nxt;
  logic            neg_r, neg_nxt;
  logic [NW-1:0]   quo_r, quo_nxt;
  logic [PW-1:0]   rem_r, rem_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [POS_W-1:0] steer_pos_r, thr_pos_r;

  // Output register
  logic            out_valid_r;
  logic            out_ok_r;
  mix_t            out_mix_r;

  // Combinational helpers
  logic [PW-1:0]   cal_lo, cal_hi;
  logic [PW:0]     diff_s, den_s;
  logic [PW+1:0]   trial;
  logic            pos_we;
  logic [POS_W-1:0] pos_val;
  logic            out_load;
  mix_t            mix;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);

  // Configuration decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steer_lo_r <= PW'(CAL_LOW_RST);
      steer_hi_r <= PW'(CAL_HIGH_RST);
      thr_lo_r   <= PW'(CAL_LOW_RST);
      thr_hi_r   <= PW'(CAL_HIGH_RST);
      db_upper_r <= REG9_W'(DB_UPPER_RST);
      db_lower_r <= REG9_W'(DB_LOWER_RST);
      ctr_up_r   <= REG9_W'(CTR_UP_RST);
      ctr_down_r <= REG9_W'(CTR_DOWN_RST);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STEER_CAL_LOW:     steer_lo_r <= cfg_data;
        REG_STEER_CAL_HIGH:    steer_hi_r <= cfg_data;
        REG_THROTTLE_CAL_LOW:  thr_lo_r   <= cfg_data;
        REG_THROTTLE_CAL_HIGH: thr_hi_r   <= cfg_data;
        REG_DEADBAND_UPPER:    db_upper_r <= cfg_data[REG9_W-1:0];
        REG_DEADBAND_LOWER:    db_lower_r <= cfg_data[REG9_W-1:0];
        REG_CENTER_UP:         ctr_up_r   <= cfg_data[REG9_W-1:0];
        REG_CENTER_DOWN:       ctr_down_r <= cfg_data[REG9_W-1:0];
        default: ;
      endcase
    end
  end

  // Calibration of the selected channel, signed offsets
  assign cal_lo = sel_r ? thr_lo_r : steer_lo_r;
  assign cal_hi = sel_r ? thr_hi_r : steer_hi_r;
  assign diff_s = {1'b0, pulse_r} - {1'b0, cal_lo};
  assign den_s  = {1'b0, cal_hi} - {1'b0, cal_lo};

  // One restoring divider step
  assign trial = {1'b0, rem_r, quo_r[NW-1]} - {2'b00, den_mag_r};

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    diff_mag_nxt = diff_mag_r;
    den_mag_nxt  = den_mag_r;
    neg_nxt      = neg_r;
    quo_nxt      = quo_r;
    rem_nxt      = rem_r;
    cnt_nxt      = cnt_r;
    pos_we       = 1'b0;
    pos_val      = '0;
    out_load     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        diff_mag_nxt = diff_s[PW] ? PW'(-diff_s) : diff_s[PW-1:0];
        den_mag_nxt  = den_s[PW] ? PW'(-den_s) : den_s[PW-1:0];
        neg_nxt      = diff_s[PW] ^ den_s[PW];
        if (!ok_r) begin
          state_nxt = ST_MIX;
        end else if (cal_hi == cal_lo) begin
          // degenerate calibration: step at the bound
          pos_we    = 1'b1;
          pos_val   = (pulse_r >= cal_lo) ? PM_POS : '0;
          state_nxt = ST_MIX;
        end else begin
          state_nxt = ST_MULT;
        end
      end
      ST_MULT: begin
        quo_nxt   = NW'({{PMW{1'b0}}, diff_mag_r} * {{PW{1'b0}}, PM_C});
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (trial[PW+1]) begin
          rem_nxt = {rem_r[PW-2:0], quo_r[NW-1]};
          quo_nxt = {quo_r[NW-2:0], 1'b0};
        end else begin
          rem_nxt = trial[PW-1:0];
          quo_nxt = {quo_r[NW-2:0], 1'b1};
        end
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == LAST_IT) begin
          state_nxt = ST_SAT;
        end
      end
      ST_SAT: begin
        // negative quotient clamps to zero, large one to full scale
        pos_we    = 1'b1;
        pos_val   = neg_r ? '0 : ((quo_r > PM_Q) ? PM_POS : POS_W'(quo_r));
        state_nxt = ST_MIX;
      end
      ST_MIX: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sel_r   <= in_channel_select;
      pulse_r <= in_pulse_width_us;
      ok_r    <= (in_pulse_width_us >= PW'(PULSE_MIN_OK)) &&
                 (in_pulse_width_us <= PW'(PULSE_MAX_OK));
    end
    diff_mag_r <= diff_mag_nxt;
    den_mag_r  <= den_mag_nxt;
    neg_r      <= neg_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
  end

  // Stored stick positions
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steer_pos_r <= POS_W'(NEUTRAL_POS);
      thr_pos_r   <= POS_W'(NEUTRAL_POS);
    end else if (pos_we) begin
      if (sel_r) begin
        thr_pos_r <= pos_val;
      end else begin
        steer_pos_r <= pos_val;
      end
    end
  end

  rcpdm_mix #(
    .POS_W (POS_W)
  ) u_mix (
    .steer_pos      (steer_pos_r),
    .throttle_pos   (thr_pos_r),
    .deadband_upper (db_upper_r),
    .deadband_lower (db_lower_r),
    .center_up      (ctr_up_r),
    .center_down    (ctr_down_r),
    .mix            (mix)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ok_r  <= ok_r;
      out_mix_r <= mix;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pulse_valid  = out_ok_r;
  assign out_left_duty    = out_mix_r.left_duty;
  assign out_left_dir     = out_mix_r.left_dir;
  assign out_right_duty   = out_mix_r.right_duty;
  assign out_right_dir    = out_mix_r.right_dir;
  assign out_neutral_lamp = out_mix_r.neutral_lamp;

`ifndef SYNTH
  // A new result only ever comes from the mix step
  a_out_from_mix: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_MIX))
    else $error("result appeared outside the mix step");

  // An accepted beat always starts the preparation step
  a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_PREP))
    else $error("accepted beat did not start processing");

  // Stored positions never exceed full scale
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (steer_pos_r <= PM_POS) && (thr_pos_r <= PM_POS))
    else $error("stored position out of range");

  // Divider never runs past its last quotient bit
  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r <= LAST_IT))
    else $error("divider iteration count overran");
`endif

endmodule

@@ tb/sv/rc_pulse_mix_checker.sv @@
`timescale 1ns / 1ps

// Watches the config, pulse and drive channels of the mixer, keeps its own
// copy of the registers and stick positions, predicts each drive beat and
// compares it with what comes out.
module rc_pulse_mix_checker import rcpdm_pkg::*; #(
  parameter int POSITION_MAX = 511,
  parameter int PULSE_BITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [PULSE_BITS-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  in_channel_select,
  input  logic [PULSE_BITS-1:0] in_pulse_width_us,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  out_pulse_valid,
  input  logic [7:0]            out_left_duty,
  input  logic [1:0]            out_left_dir,
  input  logic [7:0]            out_right_duty,
  input  logic [1:0]            out_right_dir,
  input  logic                  out_neutral_lamp,
  output int                    fail_count,
  output int                    outstanding
);

  typedef struct packed {
    logic pulse_valid;
    mix_t drive;
  } drive_beat_t;

  // Shadow registers and stick positions
  logic [PULSE_BITS-1:0] steer_lo, steer_hi, thr_lo, thr_hi;
  logic [REG9_W-1:0]     db_upper, db_lower, ctr_up, ctr_down;
  int                    steer_pos, thr_pos;
  int                    errors = 0;
  drive_beat_t           drive_q[$];

  // Linear map of a pulse onto 0..POSITION_MAX, truncating, then clamped
  function automatic int pulse_to_position(longint p, longint lo, longint hi);
    longint r;
    if (hi == lo) r = (p >= lo) ? longint'(POSITION_MAX) : longint'(0);
    else          r = ((p - lo) * POSITION_MAX) / (hi - lo);
    if (r < 0) r = 0;
    if (r > POSITION_MAX) r = longint'(POSITION_MAX);
    return int'(r);
  endfunction

  function automatic logic [7:0] clip_duty(longint d);
    if (d < 1) return 8'd0;
    if (d > DUTY_TOP - 1) return 8'(DUTY_TOP);
    return d[7:0];
  endfunction

  // Tank mix of steer x and throttle y with deadbands
  function automatic mix_t tank_mix(longint x, longint y);
    longint up, dn, cu, cd, a, b;
    mix_t   m;
    up = longint'(db_upper);
    dn = longint'(db_lower);
    cu = longint'(ctr_up);
    cd = longint'(ctr_down);
    a = 0;
    b = 0;
    m.left_dir     = DIR_STOP;
    m.right_dir    = DIR_STOP;
    m.neutral_lamp = 1'b0;
    if (y > up) begin
      m.left_dir  = DIR_FWD;
      m.right_dir = DIR_FWD;
      if (x > up) begin
        a = y - cu;
        b = (y - cu) - (x - cu);
      end else if (x < dn) begin
        a = (y - cu) - (cd - x);
        b = y - cu;
      end else begin
        a = y - cu;
        b = a;
      end
    end else if (y < dn) begin
      m.left_dir  = DIR_REV;
      m.right_dir = DIR_REV;
      if (x > up) begin
        a = cd - y;
        b = (cd - y) - (x - cu);
      end else if (x < dn) begin
        a = (cd - y) - (cd - x);
        b = cd - y;
      end else begin
        a = cd - y;
        b = a;
      end
    end else begin
      // throttle neutral: spin in place at half duty, or stop
      if (x > up) begin
        a = (x - cu) / 2;
        b = a;
        m.left_dir  = DIR_REV;
        m.right_dir = DIR_FWD;
      end else if (x < dn) begin
        a = (cd - x) / 2;
        b = a;
        m.left_dir  = DIR_FWD;
        m.right_dir = DIR_REV;
      end else begin
        m.neutral_lamp = 1'b1;
      end
    end
    m.left_duty  = clip_duty(a);
    m.right_duty = clip_duty(b);
    return m;
  endfunction

  always @(posedge clk) begin
    drive_beat_t want, got;
    int          width;
    logic        in_window;
    if (!rst_n) begin
      steer_lo  = PULSE_BITS'(CAL_LOW_RST);
      steer_hi  = PULSE_BITS'(CAL_HIGH_RST);
      thr_lo    = PULSE_BITS'(CAL_LOW_RST);
      thr_hi    = PULSE_BITS'(CAL_HIGH_RST);
      db_upper  = REG9_W'(DB_UPPER_RST);
      db_lower  = REG9_W'(DB_LOWER_RST);
      ctr_up    = REG9_W'(CTR_UP_RST);
      ctr_down  = REG9_W'(CTR_DOWN_RST);
      steer_pos = NEUTRAL_POS;
      thr_pos   = NEUTRAL_POS;
      drive_q.delete();
    end else begin
      // register write
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_STEER_CAL_LOW:     steer_lo = cfg_data;
          REG_STEER_CAL_HIGH:    steer_hi = cfg_data;
          REG_THROTTLE_CAL_LOW:  thr_lo   = cfg_data;
          REG_THROTTLE_CAL_HIGH: thr_hi   = cfg_data;
          REG_DEADBAND_UPPER:    db_upper = cfg_data[REG9_W-1:0];
          REG_DEADBAND_LOWER:    db_lower = cfg_data[REG9_W-1:0];
          REG_CENTER_UP:         ctr_up   = cfg_data[REG9_W-1:0];
          REG_CENTER_DOWN:       ctr_down = cfg_data[REG9_W-1:0];
          default: ;
        endcase
      end

      // drive beat out: compare against oldest prediction
      if (out_valid && out_ready) begin
        got.pulse_valid        = out_pulse_valid;
        got.drive.left_duty    = out_left_duty;
        got.drive.left_dir     = dir_t'(out_left_dir);
        got.drive.right_duty   = out_right_duty;
        got.drive.right_dir    = dir_t'(out_right_dir);
        got.drive.neutral_lamp = out_neutral_lamp;
        if (drive_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display({"%0t: drive beat with nothing predicted:",
                      " valid=%0d L=%0d/%0d R=%0d/%0d lamp=%0d"},
                     $time, got.pulse_valid, got.drive.left_duty, got.drive.left_dir,
                     got.drive.right_duty, got.drive.right_dir, got.drive.neutral_lamp);
        end else begin
          want = drive_q.pop_front();
          if (got.pulse_valid !== want.pulse_valid ||
              got.drive.left_duty !== want.drive.left_duty ||
              got.drive.left_dir !== want.drive.left_dir ||
              got.drive.right_duty !== want.drive.right_duty ||
              got.drive.right_dir !== want.drive.right_dir ||
              got.drive.neutral_lamp !== want.drive.neutral_lamp) begin
            errors++;
            if (errors <= 10)
              $display({"%0t: drive mismatch exp valid=%0d L=%0d/%0d R=%0d/%0d lamp=%0d",
                        " got valid=%0d L=%0d/%0d R=%0d/%0d lamp=%0d"},
                       $time, want.pulse_valid, want.drive.left_duty, want.drive.left_dir,
                       want.drive.right_duty, want.drive.right_dir, want.drive.neutral_lamp,
                       got.pulse_valid, got.drive.left_duty, got.drive.left_dir,
                       got.drive.right_duty, got.drive.right_dir, got.drive.neutral_lamp);
          end
        end
      end

      // pulse beat in: update position if in window, then mix
      if (in_valid && in_ready) begin
        width     = int'(in_pulse_width_us);
        in_window = (width >= PULSE_MIN_OK) && (width <= PULSE_MAX_OK);
        if (in_window) begin
          if (!in_channel_select) begin
            steer_pos = pulse_to_position(longint'(width), longint'(steer_lo),
                                          longint'(steer_hi));
          end else begin
            thr_pos   = pulse_to_position(longint'(width), longint'(thr_lo),
                                          longint'(thr_hi));
          end
        end
        want.pulse_valid = in_window;
        want.drive       = tank_mix(longint'(steer_pos), longint'(thr_pos));
        drive_q.push_back(want);
      end
    end
    fail_count  <= errors;
    outstanding <= drive_q.size();
  end

endmodule

@@ tb/sv/rc_pulse_differential_drive_mixer_tb.sv @@
`timescale 1ns / 1ps

module rc_pulse_differential_drive_mixer_tb import rcpdm_pkg::*;;

  localparam int   POSITION_MAX = 511;
  localparam int   PULSE_BITS   = 16;
  localparam int   STALL_LIMIT  = 5000;
  localparam int   HALF_ITEMS   = 96;
  localparam logic CH_STEER     = 1'b0;
  localparam logic CH_THROTTLE  = 1'b1;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [REG_IDX_W-1:0]  cfg_index = '0;
  logic [PULSE_BITS-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_channel_select = 1'b0;
  logic [PULSE_BITS-1:0] in_pulse_width_us = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  logic                  out_pulse_valid;
  logic [7:0]            out_left_duty;
  logic [1:0]            out_left_dir;
  logic [7:0]            out_right_duty;
  logic [1:0]            out_right_dir;
  logic                  out_neutral_lamp;

  int fail_count;
  int outstanding;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;

  always #10 clk = ~clk;

  rc_pulse_differential_drive_mixer #(
    .POSITION_MAX(POSITION_MAX),
    .PULSE_BITS  (PULSE_BITS)
  ) dut (.*);

  rc_pulse_mix_checker #(
    .POSITION_MAX(POSITION_MAX),
    .PULSE_BITS  (PULSE_BITS)
  ) checker_i (.*);

  // Receiver backpressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: cycles without any beat moving
  always @(posedge clk) begin
    if (!rst_n || (cfg_valid && cfg_ready) || (in_valid && in_ready) ||
        (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
      default: begin send_idle_pct = 6; recv_stall_pct = 6; end
    endcase
  endtask

  // One pulse beat; valid holds until taken
  task automatic send_pulse(input logic sel, input logic [PULSE_BITS-1:0] width);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid          = 1'b1;
    in_channel_select = sel;
    in_pulse_width_us = width;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [PULSE_BITS-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Wait until every predicted drive beat has come out
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic program_regs(input logic [PULSE_BITS-1:0] sl, sh, tl, th, du, dl, cu, cd);
    write_reg(REG_STEER_CAL_LOW, sl);
    write_reg(REG_STEER_CAL_HIGH, sh);
    write_reg(REG_THROTTLE_CAL_LOW, tl);
    write_reg(REG_THROTTLE_CAL_HIGH, th);
    write_reg(REG_DEADBAND_UPPER, du);
    write_reg(REG_DEADBAND_LOWER, dl);
    write_reg(REG_CENTER_UP, cu);
    write_reg(REG_CENTER_DOWN, cd);
  endtask

  // Mostly in-window pulses, some around the window edges, some anything
  function automatic logic [PULSE_BITS-1:0] pick_pulse();
    int roll;
    roll = $urandom_range(99);
    if (roll < 82) return PULSE_BITS'($urandom_range(PULSE_MAX_OK, PULSE_MIN_OK));
    if (roll < 92) begin
      if ($urandom_range(1)) return PULSE_BITS'($urandom_range(PULSE_MIN_OK + 5, PULSE_MIN_OK - 5));
      return PULSE_BITS'($urandom_range(PULSE_MAX_OK + 5, PULSE_MAX_OK - 5));
    end
    return PULSE_BITS'($urandom);
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed beats at reset calibration
    set_idling(0);
    send_pulse(CH_STEER, 16'd0);
    send_pulse(CH_THROTTLE, 16'hFFFF);
    send_pulse(CH_STEER, 16'd599);
    send_pulse(CH_THROTTLE, 16'd2401);
    send_pulse(CH_STEER, 16'hAAAA);
    send_pulse(CH_THROTTLE, 16'h5555);
    send_pulse(CH_THROTTLE, 16'd2400);  // full forward, straight
    send_pulse(CH_STEER, 16'd2400);     // forward, turning right
    send_pulse(CH_STEER, 16'd600);      // forward, turning left
    send_pulse(CH_THROTTLE, 16'd600);   // reverse, left
    send_pulse(CH_STEER, 16'd2400);     // reverse, right
    send_pulse(CH_STEER, 16'd1500);     // reverse, straight
    send_pulse(CH_THROTTLE, 16'd1500);  // both neutral: stop, lamp on
    send_pulse(CH_STEER, 16'd1900);     // spin one way
    send_pulse(CH_STEER, 16'd1100);     // spin the other way
    send_pulse(CH_STEER, 16'd1531);     // right on upper deadband
    send_pulse(CH_STEER, 16'd1533);     // just above it
    send_pulse(CH_STEER, 16'd1468);     // right on lower deadband
    send_pulse(CH_STEER, 16'd1467);     // just below it
    send_pulse(CH_THROTTLE, 16'd1533);  // forward with left mix going negative
    send_pulse(CH_THROTTLE, 16'd1100);
    send_pulse(CH_THROTTLE, 16'd1900);
    send_pulse(CH_STEER, 16'd1900);
    send_pulse(CH_THROTTLE, 16'd1467);

    for (int phase = 0; phase < 8; phase++) begin
      drain();
      case (phase)
        1: program_regs(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd511, 16'd511, 16'd0);
        2: program_regs(16'd1500, 16'd1500, 16'd2400, 16'd2400, 16'd300, 16'd200, 16'd0, 16'd511);
        3: program_regs(16'd1000, 16'd2000, 16'd1000, 16'd2000, 16'd511, 16'd0, 16'd256, 16'd255);
        4: program_regs(16'd1100, 16'd1900, 16'd1900, 16'd1100, 16'd300, 16'd200, 16'd300, 16'd200);
        5: program_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        6: program_regs(16'd1450, 16'd1550, 16'd1450, 16'd1550, 16'd257, 16'd254, 16'd256, 16'd255);
        7: program_regs(PULSE_BITS'(CAL_LOW_RST), PULSE_BITS'(CAL_HIGH_RST),
                        PULSE_BITS'(CAL_LOW_RST), PULSE_BITS'(CAL_HIGH_RST),
                        PULSE_BITS'(DB_UPPER_RST), PULSE_BITS'(DB_LOWER_RST),
                        PULSE_BITS'(CTR_UP_RST), PULSE_BITS'(CTR_DOWN_RST));
        default: ;
      endcase
      for (int half = 0; half < 2; half++) begin
        set_idling((2 * phase + half) % 4);
        for (int n = 0; n < HALF_ITEMS; n++)
          send_pulse(logic'($urandom_range(1)), pick_pulse());
      end
    end

    drain();
    set_idling(0);
    repeat (40) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
